// ===== hw/rtl/btbs_pkg.sv =====
// Package for the branch target buffer stall block.
// Holds the branch modes, the two-bit status codes, the status transition
// and the result struct shared by the update logic and the top level.
package btbs_pkg;

    // Address and stream widths.
    localparam int ADDR_W         = 32;
    localparam int INDEX_BITS_DEF = 6;
    localparam int S_TDATA_W      = 72;
    localparam int M_TDATA_W      = 8;

    // Branch handling policy selected by the mode register.
    typedef enum logic [1:0] {
        MODE_FLUSH     = 2'd0,
        MODE_NOT_TAKEN = 2'd1,
        MODE_IDEAL     = 2'd2,
        MODE_DYNAMIC   = 2'd3
    } branch_mode_t;

    // Two-bit status codes of a buffer entry.
    typedef enum logic [1:0] {
        ST_SURE_NT   = 2'd0,
        ST_UNSURE_NT = 2'd1,
        ST_UNSURE_T  = 2'd2,
        ST_SURE_T    = 2'd3
    } status_t;

    // Outcome of one buffer lookup.
    typedef struct packed {
        logic    stall;
        status_t status;
    } btbs_upd_t;

    // Status transition on a hit.
    function automatic status_t next_status(input status_t s, input logic tk);
        status_t r;
        if (tk) begin
            r = (s == ST_SURE_NT) ? ST_UNSURE_T : ST_SURE_T;
        end else begin
            r = (s == ST_SURE_T) ? ST_UNSURE_T : ST_SURE_NT;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/btbs_mem.sv =====
// Direct-mapped entry storage of the branch target buffer.
// Valid bits, tags, targets and status in arrays with registered reads;
// depends on btbs_pkg for the status type.
module btbs_mem
    import btbs_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [INDEX_BITS-1:0]     rd_idx,
    output logic                      rd_valid,
    output logic [ADDR_W-INDEX_BITS-3:0] rd_tag,
    output logic [ADDR_W-1:0]         rd_target,
    output status_t                   rd_status,
    input  logic                      wr_en,
    input  logic [INDEX_BITS-1:0]     wr_idx,
    input  logic [ADDR_W-INDEX_BITS-3:0] wr_tag,
    input  logic [ADDR_W-1:0]         wr_target,
    input  status_t                   wr_status,
    input  logic                      clr_en,
    input  logic [INDEX_BITS-1:0]     clr_idx
);

    localparam int DEPTH = 1 << INDEX_BITS;
    localparam int TAG_W = ADDR_W - INDEX_BITS - 2;

    logic              valid_mem  [DEPTH];
    logic [TAG_W-1:0]  tag_mem    [DEPTH];
    logic [ADDR_W-1:0] target_mem [DEPTH];
    status_t           status_mem [DEPTH];

    // Valid bits: the clearing pass writes zero, an install writes one.
    always_ff @(posedge aclk) begin
        if (clr_en) begin
            valid_mem[clr_idx] <= 1'b0;
        end else if (wr_en) begin
            valid_mem[wr_idx] <= 1'b1;
        end
        if (rd_en) begin
            rd_valid <= valid_mem[rd_idx];
        end
    end

    // Entry payload, written only by lookups in dynamic mode.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_mem[wr_idx]    <= wr_tag;
            target_mem[wr_idx] <= wr_target;
            status_mem[wr_idx] <= wr_status;
        end
        if (rd_en) begin
            rd_tag    <= tag_mem[rd_idx];
            rd_target <= target_mem[rd_idx];
            rd_status <= status_mem[rd_idx];
        end
    end

endmodule

// ===== hw/rtl/btbs_update.sv =====
// Lookup decision of the branch target buffer for one branch.
// Compares tag and target, picks the stall and the new status;
// depends on btbs_pkg for the status transition.
module btbs_update
    import btbs_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                         taken,
    input  logic [ADDR_W-INDEX_BITS-3:0] tag_in,
    input  logic [ADDR_W-1:0]            target_in,
    input  logic                         ent_valid,
    input  logic [ADDR_W-INDEX_BITS-3:0] ent_tag,
    input  logic [ADDR_W-1:0]            ent_target,
    input  status_t                      ent_status,
    output btbs_upd_t                    upd
);

    logic hit;

    assign hit = ent_valid && (ent_tag == tag_in);

    // A miss stalls on a taken branch; a hit stalls on a wrong target.
    always_comb begin
        if (hit) begin
            upd.stall  = (ent_target != target_in);
            upd.status = next_status(ent_status, taken);
        end else begin
            upd.stall  = taken;
            upd.status = taken ? ST_UNSURE_T : ST_UNSURE_NT;
        end
    end

endmodule

// ===== hw/rtl/branch_target_buffer_stall.sv =====
// Branch stall unit: reports whether each resolved branch costs a stall.
// Each item passes the stage one register, then the result register; one item per cycle
// is sustained while the result side takes results, with the entry update done as each item leaves.
// After reset the valid bits are cleared one entry per cycle, over all 2^INDEX_BITS
// entries, while no item is accepted; the mode register resets to flush.
// Depends on btbs_pkg, btbs_mem and btbs_update.
module branch_target_buffer_stall
    import btbs_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Mode register write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data,
    // Branch items. Fields from bit 0: taken [0], branch_address [32:1],
    // target_address [64:33], zero fill [71:65].
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result items. Fields from bit 0: stall_res [0], zero fill [7:1].
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int TAG_W = ADDR_W - INDEX_BITS - 2;

    branch_mode_t mode_reg;
    logic [INDEX_BITS:0] clr_cnt_reg;
    logic clearing;

    logic                  s1_valid_reg;
    logic                  s1_taken_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [ADDR_W-1:0]     s1_target_reg;

    logic                  byp_hit_reg;
    logic [TAG_W-1:0]      byp_tag_reg;
    logic [ADDR_W-1:0]     byp_target_reg;
    status_t               byp_status_reg;

    logic                  m_tvalid_reg;
    logic                  stall_reg;
    logic                  stall_next;

    logic                  in_taken;
    logic [ADDR_W-1:0]     in_addr;
    logic [ADDR_W-1:0]     in_target;
    logic [INDEX_BITS-1:0] in_idx;
    logic                  accept;
    logic                  s1_adv;

    logic [INDEX_BITS-1:0] s1_idx;
    logic [TAG_W-1:0]      s1_tag;
    logic                  rd_valid;
    logic [TAG_W-1:0]      rd_tag;
    logic [ADDR_W-1:0]     rd_target;
    status_t               rd_status;
    logic                  ent_valid;
    logic [TAG_W-1:0]      ent_tag;
    logic [ADDR_W-1:0]     ent_target;
    status_t               ent_status;
    btbs_upd_t             upd;
    logic                  wr_en;

    // Input field unpacking.
    assign in_taken  = s_tdata[0];
    assign in_addr   = s_tdata[ADDR_W:1];
    assign in_target = s_tdata[2*ADDR_W:ADDR_W+1];
    assign in_idx    = in_addr[INDEX_BITS+1:2];

    // Handshake: stage one moves on when the result register is free or being taken.
    assign clearing  = !clr_cnt_reg[INDEX_BITS];
    assign s1_adv    = !m_tvalid_reg || m_tready;
    assign s_tready  = !clearing && (!s1_valid_reg || s1_adv);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Mode register and the post-reset clearing counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_FLUSH;
            clr_cnt_reg <= '0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= branch_mode_t'(cfg_data);
            end
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign s1_idx = s1_addr_reg[INDEX_BITS+1:2];
    assign s1_tag = s1_addr_reg[ADDR_W-1:INDEX_BITS+2];
    assign wr_en  = s1_valid_reg && s1_adv && (mode_reg == MODE_DYNAMIC);

    btbs_mem #(
        .INDEX_BITS (INDEX_BITS)
    ) u_mem (
        .aclk      (aclk),
        .rd_en     (accept),
        .rd_idx    (in_idx),
        .rd_valid  (rd_valid),
        .rd_tag    (rd_tag),
        .rd_target (rd_target),
        .rd_status (rd_status),
        .wr_en     (wr_en),
        .wr_idx    (s1_idx),
        .wr_tag    (s1_tag),
        .wr_target (s1_target_reg),
        .wr_status (upd.status),
        .clr_en    (clearing),
        .clr_idx   (clr_cnt_reg[INDEX_BITS-1:0])
    );

    // Stage one register, with a bypass of the entry written in the same
    // cycle as this item's read (that read returns the old contents).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end else begin
            if (s1_adv || !s1_valid_reg) begin
                s1_valid_reg <= accept;
            end
            if (accept) begin
                byp_hit_reg <= wr_en && (s1_idx == in_idx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_taken_reg   <= in_taken;
            s1_addr_reg    <= in_addr;
            s1_target_reg  <= in_target;
            byp_tag_reg    <= s1_tag;
            byp_target_reg <= s1_target_reg;
            byp_status_reg <= upd.status;
        end
    end

    // Entry seen by this item.
    assign ent_valid  = byp_hit_reg ? 1'b1           : rd_valid;
    assign ent_tag    = byp_hit_reg ? byp_tag_reg    : rd_tag;
    assign ent_target = byp_hit_reg ? byp_target_reg : rd_target;
    assign ent_status = byp_hit_reg ? byp_status_reg : rd_status;

    btbs_update #(
        .INDEX_BITS (INDEX_BITS)
    ) u_update (
        .taken      (s1_taken_reg),
        .tag_in     (s1_tag),
        .target_in  (s1_target_reg),
        .ent_valid  (ent_valid),
        .ent_tag    (ent_tag),
        .ent_target (ent_target),
        .ent_status (ent_status),
        .upd        (upd)
    );

    // Stall decision by mode.
    always_comb begin
        case (mode_reg)
            MODE_FLUSH:     stall_next = 1'b1;
            MODE_NOT_TAKEN: stall_next = s1_taken_reg;
            MODE_IDEAL:     stall_next = 1'b0;
            MODE_DYNAMIC:   stall_next = upd.stall;
            default:        stall_next = 1'b1;
        endcase
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_tvalid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            stall_reg <= stall_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, stall_reg};

endmodule
